// ===== src/hafe_pkg.sv =====
// Package for the hex ASCII frame encoder.
// Holds the item codes, the frame descriptor type and the character helpers.
// It depends on nothing else; all but the two interface files import it.
package hafe_pkg;

  localparam int HAFE_QUEUE_DEPTH = 2;

  // Input item kinds.
  localparam logic [1:0] REQ_ADDR = 2'd0;
  localparam logic [1:0] REQ_ID   = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Frame characters.
  localparam logic [6:0] CH_T  = 7'h54;
  localparam logic [6:0] CH_S  = 7'h53;
  localparam logic [6:0] CH_X  = 7'h58;
  localparam logic [6:0] CH_CR = 7'h0D;
  localparam logic [6:0] CH_LF = 7'h0A;

  typedef enum logic [1:0] {
    OP_ADDR,
    OP_BYTE,
    OP_CLOSE
  } op_t;

  // One queued word: everything the back end needs to spell out one item.
  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic       ck;     // S frame on an address, checksum trailer on a close
    logic [6:0] xsum;
  } desc_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       frame_end;
  } char_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = 7'h30 + {3'b000, nib};
    end else begin
      hex_char = 7'h37 + {3'b000, nib};
    end
  endfunction

  function automatic logic [2:0] char_count(input desc_t d);
    unique case (d.op)
      OP_ADDR:  char_count = 3'd4;
      OP_BYTE:  char_count = 3'd2;
      OP_CLOSE: char_count = d.ck ? 3'd6 : 3'd4;
      default:  char_count = 3'd2;
    endcase
  endfunction

  function automatic char_t char_at(input desc_t d, input logic [2:0] idx);
    logic [2:0] slot;
    char_t      c;
    slot        = idx;
    c.frame_end = 1'b0;
    // A close without checksum skips the two trailer digits.
    if (d.op == OP_CLOSE && !d.ck && idx >= 3'd2) begin
      slot = idx + 3'd2;
    end
    if (d.op == OP_ADDR) begin
      unique case (idx)
        3'd0:    c.ch = CH_T;
        3'd1:    c.ch = d.ck ? CH_S : CH_X;
        3'd2:    c.ch = hex_char(d.value[7:4]);
        3'd3:    c.ch = hex_char(d.value[3:0]);
        default: c.ch = CH_T;
      endcase
    end else begin
      unique case (slot)
        3'd0:    c.ch = hex_char(d.value[7:4]);
        3'd1:    c.ch = hex_char(d.value[3:0]);
        3'd2:    c.ch = hex_char({1'b0, d.xsum[6:4]});
        3'd3:    c.ch = hex_char(d.xsum[3:0]);
        3'd4:    c.ch = CH_CR;
        3'd5: begin
          c.ch        = CH_LF;
          c.frame_end = 1'b1;
        end
        default: c.ch = CH_CR;
      endcase
    end
    char_at = c;
  endfunction

endpackage

// ===== src/hafe_in_if.sv =====
// Input channel of the hex ASCII frame encoder: valid/ready plus one item.
// Depends on nothing.
interface hafe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] value;
  logic       last;
  logic       with_checksum;

  modport source (output valid, req_type, value, last, with_checksum, input ready);
  modport sink   (input valid, req_type, value, last, with_checksum, output ready);
endinterface

// ===== src/hafe_out_if.sv =====
// Character channel of the hex ASCII frame encoder: valid/ready plus one character.
// Depends on nothing.
interface hafe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_out;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, char_out, frame_end, run_last, input ready);
  modport sink   (input valid, char_out, frame_end, run_last, output ready);
endinterface

// ===== src/hafe_front.sv =====
// Front end: accepts input words, keeps the frame mode and running XOR, and
// queues a descriptor per address, id or data word. Uses hafe_pkg, hafe_in_if.
module hafe_front
  import hafe_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  hafe_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output desc_t  q_wdata
);

  logic       mode_r, mode_nxt;
  logic [6:0] xor_r, xor_nxt;
  logic       accept;
  logic [6:0] hi, lo, fold;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  assign hi   = hex_char(in_ch.value[7:4]);
  assign lo   = hex_char(in_ch.value[3:0]);
  assign fold = xor_r ^ hi ^ lo;

  always_comb begin
    mode_nxt      = mode_r;
    xor_nxt       = xor_r;
    q_push        = 1'b0;
    q_wdata.op    = OP_BYTE;
    q_wdata.value = in_ch.value;
    q_wdata.ck    = mode_r;
    q_wdata.xsum  = fold;
    if (accept) begin
      unique case (in_ch.req_type)
        REQ_ADDR: begin
          mode_nxt   = in_ch.with_checksum;
          xor_nxt    = hi ^ lo;
          q_push     = 1'b1;
          q_wdata.op = OP_ADDR;
          q_wdata.ck = in_ch.with_checksum;
        end
        REQ_ID, REQ_DATA: begin
          q_push = 1'b1;
          if (in_ch.last) begin
            q_wdata.op = OP_CLOSE;
            xor_nxt    = 7'd0;
          end else begin
            xor_nxt = fold;
          end
        end
        REQ_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      xor_r  <= 7'd0;
    end else begin
      mode_r <= mode_nxt;
      xor_r  <= xor_nxt;
    end
  end

endmodule

// ===== src/hafe_queue.sv =====
// Short descriptor queue between the front and back ends of the encoder.
// Uses hafe_pkg for the descriptor type.
module hafe_queue
  import hafe_pkg::*;
#(
  parameter int DEPTH = HAFE_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

// ===== src/hafe_back.sv =====
// Back end: spells the queue head out one character per cycle, unless out_ch stalls, into an
// output register, popping the descriptor with its final character. Uses hafe_pkg, hafe_out_if.
module hafe_back
  import hafe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  desc_t      head,
  output logic       pop,
  hafe_out_if.source out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic [6:0] char_r;
  logic       frame_end_r;
  logic       run_last_r;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] count;
  char_t      cur;
  logic       load, emit, last_char;

  assign count     = char_count(head);
  assign cur       = char_at(head, idx_r);
  assign last_char = (idx_r == count - 3'd1);
  assign load      = !out_valid_r || out_ch.ready;
  assign emit      = head_valid && load;
  assign pop       = emit && last_char;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      idx_nxt       = last_char ? 3'd0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r      <= cur.ch;
      frame_end_r <= cur.frame_end;
      run_last_r  <= last_char;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_out  = char_r;
  assign out_ch.frame_end = frame_end_r;
  assign out_ch.run_last  = run_last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r < count)
    else $error("character index past the end of the descriptor");

  a_frame_end_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> (char_r == CH_LF && run_last_r))
    else $error("frame end flagged on a character other than the closing LF");

endmodule

// ===== src/hex_ascii_frame_encoder_top.sv =====
// Top level of the hex ASCII frame encoder: front end, descriptor queue, back end.
// Uses hafe_pkg, hafe_in_if, hafe_out_if, hafe_front, hafe_queue, hafe_back.
//
//  channel | dir | handshake        | word
//  in_ch   | in  | valid/ready      | req_type, value, last, with_checksum
//  out_ch  | out | valid/ready      | char_out, frame_end, run_last
//
// The back end forms each character into the output register, which holds it until
// out_ch takes it. It forms one character per cycle while out_ch does not stall:
// an address word spells 4 characters, an id or data word 2, a closing word 4 or 6
// (with checksum). The front end takes a word in the cycle it arrives whenever the
// queue has room, even while earlier words are spelled out. Words of unused kind are
// taken and dropped. Reset is synchronous and clears the mode, XOR and queue.
// A stall on out_ch holds the output register and backs up through the queue to in_ch.
module hex_ascii_frame_encoder_top
  import hafe_pkg::*;
#(
  parameter int QUEUE_DEPTH = HAFE_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  hafe_in_if.sink    in_ch,
  hafe_out_if.source out_ch
);

  logic  q_push, q_full, q_pop, q_head_valid;
  desc_t q_wdata, q_head;

  hafe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  hafe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  hafe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for hex_ascii_frame_encoder_top: directed and random item words in, characters out.
// Predicts every character from its own frame model and scores the character channel.
// Depends on hafe_pkg, hafe_in_if, hafe_out_if and the encoder RTL.
module tb;
  import hafe_pkg::*;

  localparam int HOLD_OFF_CYCLES = 100;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct {
    logic [6:0] ch;
    logic       fend;
    logic       rlast;
  } exp_char_t;

  logic clk = 1'b0;
  logic rst_n;

  hafe_in_if  in_ch();
  hafe_out_if out_ch();

  hex_ascii_frame_encoder_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame model state and the characters still owed by the block.
  logic       frame_ck;
  logic [6:0] frame_xor;
  exp_char_t  char_fifo[$];

  int words_sent;
  int mismatch_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req_cnt;
  int hold_ack_cnt;
  int hold_left;
  int quiet_cycles;

  function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return 7'h41 + {3'b000, nib} - 7'd10;
    end
    return 7'h30 + {3'b000, nib};
  endfunction

  // Works out the characters one accepted word causes and advances the frame state.
  function automatic void spell_word(input logic [1:0] kind, input logic [7:0] val,
                                     input logic lst, input logic ck);
    exp_char_t  seq [6];
    int         n;
    logic [6:0] hi;
    logic [6:0] lo;
    n = 0;
    if (kind == REQ_NONE) begin
      return;
    end
    hi = hex_ascii(val[7:4]);
    lo = hex_ascii(val[3:0]);
    if (kind == REQ_ADDR) begin
      frame_ck  = ck;
      frame_xor = '0;
      seq[0]    = '{CH_T, 1'b0, 1'b0};
      seq[1]    = '{(ck ? CH_S : CH_X), 1'b0, 1'b0};
      n         = 2;
    end
    seq[n]     = '{hi, 1'b0, 1'b0};
    seq[n + 1] = '{lo, 1'b0, 1'b0};
    n          = n + 2;
    frame_xor  = frame_xor ^ hi ^ lo;
    // The last flag only closes a frame on id and data words.
    if (kind != REQ_ADDR && lst) begin
      if (frame_ck) begin
        seq[n]     = '{hex_ascii({1'b0, frame_xor[6:4]}), 1'b0, 1'b0};
        seq[n + 1] = '{hex_ascii(frame_xor[3:0]), 1'b0, 1'b0};
        n          = n + 2;
      end
      seq[n]     = '{CH_CR, 1'b0, 1'b0};
      seq[n + 1] = '{CH_LF, 1'b1, 1'b0};
      n          = n + 2;
      frame_xor  = '0;
    end
    seq[n - 1].rlast = 1'b1;
    for (int i = 0; i < n; i++) begin
      char_fifo.push_back(seq[i]);
    end
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows acceptance.
  task automatic send_word(input logic [1:0] kind, input logic [7:0] val,
                           input logic lst, input logic ck);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= kind;
    in_ch.value         <= val;
    in_ch.last          <= lst;
    in_ch.with_checksum <= ck;
    forever begin
      @(posedge clk);
      if (in_ch.ready) begin
        break;
      end
    end
    spell_word(kind, val, lst, ck);
    if (kind != REQ_NONE) begin
      words_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_random_frame();
    int   body;
    logic ck;
    logic broken;
    ck     = 1'($urandom_range(1, 0));
    body   = $urandom_range(6, 1);
    broken = ($urandom_range(99, 0) < 10);
    send_word(REQ_ADDR, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), ck);
    for (int i = 0; i < body; i++) begin
      send_word(2'($urandom_range(2, 1)), 8'($urandom_range(255, 0)),
                (i == body - 1) && !broken, 1'($urandom_range(1, 0)));
    end
  endtask

  task automatic send_noise_word();
    send_word(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
              1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endtask

  task automatic test_directed_frames();
    // Checksummed frame with extreme bytes, then a plain one.
    send_word(REQ_ADDR, 8'h00, 1'b0, 1'b1);
    send_word(REQ_ID,   8'hFF, 1'b0, 1'b0);
    send_word(REQ_DATA, 8'h7F, 1'b0, 1'b0);
    send_word(REQ_DATA, 8'h80, 1'b1, 1'b0);
    send_word(REQ_ADDR, 8'hFF, 1'b0, 1'b0);
    send_word(REQ_ID,   8'h0A, 1'b0, 1'b1);
    send_word(REQ_DATA, 8'h5A, 1'b1, 1'b1);
    // Id alone closing a checksummed frame.
    send_word(REQ_ADDR, 8'h9E, 1'b0, 1'b1);
    send_word(REQ_ID,   8'hC3, 1'b1, 1'b0);
  endtask

  task automatic test_stray_words();
    // Unused kind: nothing comes out and the open frame is untouched.
    send_word(REQ_ADDR, 8'h12, 1'b0, 1'b1);
    send_word(REQ_NONE, 8'hA5, 1'b1, 1'b1);
    send_word(REQ_DATA, 8'h34, 1'b1, 1'b0);
    // Words after a closed frame still fold into the checksum under the old mode.
    send_word(REQ_DATA, 8'hE1, 1'b0, 1'b0);
    send_word(REQ_ID,   8'h0F, 1'b1, 1'b1);
    // Last on an address leaves the frame open.
    send_word(REQ_ADDR, 8'hF0, 1'b1, 1'b0);
    send_word(REQ_DATA, 8'h3C, 1'b0, 1'b1);
    // A new address in mid frame restarts it.
    send_word(REQ_ADDR, 8'h66, 1'b0, 1'b1);
    send_word(REQ_ID,   8'hB7, 1'b1, 1'b0);
    send_word(REQ_NONE, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int count);
    int start;
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
    start          = words_sent;
    while (words_sent - start < count) begin
      if ($urandom_range(99, 0) < 15) begin
        send_noise_word();
      end else begin
        send_random_frame();
      end
    end
  endtask

  task automatic test_back_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_cnt++;
    send_random_frame();
    send_random_frame();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_NONE;
    in_ch.value         = '0;
    in_ch.last          = 1'b0;
    in_ch.with_checksum = 1'b0;
    out_ch.ready        = 1'b0;
    frame_ck            = 1'b0;
    frame_xor           = '0;
    words_sent          = 0;
    mismatch_cnt        = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req_cnt        = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Before any address the mode is plain, so stray words close without a checksum.
    send_word(REQ_DATA, 8'h00, 1'b0, 1'b1);
    send_word(REQ_ID,   8'hFF, 1'b1, 1'b1);
    test_directed_frames();
    test_stray_words();
    test_random_traffic(0, 0, 28);
    test_random_traffic(80, 0, 28);
    test_random_traffic(0, 80, 28);
    test_random_traffic(8, 8, 28);
    test_back_pressure();
    in_ch.valid    <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (char_fifo.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever the test asks for one.
  initial begin
    hold_ack_cnt = 0;
    hold_left    = 0;
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    = hold_left - 1;
    end else if (hold_ack_cnt != hold_req_cnt) begin
      out_ch.ready <= 1'b0;
      hold_ack_cnt = hold_req_cnt;
      hold_left    = HOLD_OFF_CYCLES - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_chars
    exp_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (char_fifo.size() == 0) begin
        $error("unexpected word: char_out=%h frame_end=%b run_last=%b",
               out_ch.char_out, out_ch.frame_end, out_ch.run_last);
        mismatch_cnt++;
      end else begin
        want = char_fifo.pop_front();
        if (out_ch.char_out !== want.ch) begin
          $error("char_out: expected %h, got %h", want.ch, out_ch.char_out);
          mismatch_cnt++;
        end
        if (out_ch.frame_end !== want.fend) begin
          $error("frame_end: expected %b, got %b", want.fend, out_ch.frame_end);
          mismatch_cnt++;
        end
        if (out_ch.run_last !== want.rlast) begin
          $error("run_last: expected %b, got %b", want.rlast, out_ch.run_last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a word.
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
